[hdl/pss_pkg.sv]
// Shared types and constants for the process slot scheduler.
package pss_pkg;

  localparam int PROC_SLOTS_DEF = 64;
  localparam int PARENT_W       = 9;   // holds a slot number or the no-parent mark
  localparam int COUNT_W        = 7;
  localparam int PRIO_W         = 6;
  localparam int PID_W          = 16;
  localparam int TAG_W          = 16;
  localparam int SLOT_W         = 6;
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 24;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_SLEEP  = 3'd1,
    OP_WAKEUP = 3'd2,
    OP_PICK   = 3'd3,
    OP_TICK   = 3'd4,
    OP_EXIT   = 3'd5,
    OP_REAP   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    RS_DONE    = 2'd0,
    RS_NONE    = 2'd1,
    RS_REFUSED = 2'd2
  } res_status_t;

  typedef enum logic [1:0] {
    SS_UNUSED   = 2'd0,
    SS_RUNNING  = 2'd1,
    SS_SLEEPING = 2'd2,
    SS_ZOMBIE   = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_FINISH
  } fsm_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [PARENT_W-1:0] parent;
    logic [PID_W-1:0]    pid;
    logic [PRIO_W-1:0]   prio;
    logic [COUNT_W-1:0]  count;
    slot_state_t         st;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

endpackage

[hdl/pss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pss_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/process_slot_scheduler_top.sv]
// Process slot scheduler: process table in one RAM, swept by a read-modify-write engine.
//
// Usage: items enter on the in_ channel (operation, slot, channel, priority,
// parent); every item yields exactly one result item on the out_ channel
// (status, chosen slot, pid). cfg_wen/cfg_wdata set the init slot; the user must write
// it only while idle, as the block itself does not enforce this. All slot state sits
// in one RAM record per slot with a registered read. Each item makes a scan pass over
// the table, and most operations a second read-modify-write pass over it; a pick
// that finds a running slot with a nonzero count on the first pass finishes after that pass.
// The rate is set by the single RAM read port, one slot record per cycle.
// After reset the engine clears the RAM, one slot a cycle; in_tready stays low
// until the clear is done. One item is in work at a time.
// The result sits in an output register: the next item is taken while it
// waits, and a finished item waits until that register is free.
module process_slot_scheduler_top #(
  parameter int PROC_SLOTS = pss_pkg::PROC_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // operation[2:0], slot[8:3], channel[24:9], priority_req[30:25],
  // parent_slot[36:31], parent_valid[37], zero fill above
  input  logic [pss_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[1:0], chosen_slot[7:2], result_pid[23:8]
  output logic [pss_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wen,
  input  logic [pss_pkg::SLOT_W-1:0]     cfg_wdata
);
  import pss_pkg::*;

  localparam int AW = $clog2(PROC_SLOTS);
  localparam int CW = AW + 1;
  localparam logic [PARENT_W-1:0] NO_PARENT = PARENT_W'(PROC_SLOTS);
  localparam logic [CW-1:0] CNT_END  = CW'(PROC_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(PROC_SLOTS - 1);

  fsm_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [SLOT_W-1:0] init_r, init_nxt;
  logic [PID_W-1:0] pidc_r, pidc_nxt;
  logic out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  op_t op_r, op_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [TAG_W-1:0] chan_r, chan_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic [SLOT_W-1:0] par_r, par_nxt;
  logic pv_r, pv_nxt;
  logic free_fnd_r, free_fnd_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic kid_fnd_r, kid_fnd_nxt;
  logic [AW-1:0] kid_idx_r, kid_idx_nxt;
  logic [PID_W-1:0] kid_pid_r, kid_pid_nxt;
  logic best_fnd_r, best_fnd_nxt;
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  logic [COUNT_W-1:0] best_cnt_r, best_cnt_nxt;
  slot_state_t self_st_r, self_st_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [PID_W-1:0] newpid_r, newpid_nxt;
  res_status_t stat_r, stat_nxt;
  logic [SLOT_W-1:0] chos_r, chos_nxt;
  logic [PID_W-1:0] rpid_r, rpid_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  slot_rec_t ram_wdata, ram_rdata, rec, upd, rst_rec;
  logic last, accept, slot_ok, is_self, is_tgt, apply;
  logic [PARENT_W-1:0] adopt;

  pss_ram #(.W(REC_W), .D(PROC_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign rec        = ram_rdata;
  assign last       = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign slot_ok    = 32'(slot_r) < PROC_SLOTS;
  assign is_self    = 32'(rd_idx_r) == 32'(slot_r);
  assign is_tgt     = rd_idx_r == tgt_r;
  assign adopt      = (32'(init_r) < PROC_SLOTS) ? PARENT_W'(init_r) : NO_PARENT;

  always_comb begin
    rst_rec        = '0;
    rst_rec.st     = SS_UNUSED;
    rst_rec.parent = NO_PARENT;
  end

  // Second-pass update of one slot record.
  always_comb begin
    upd = rec;
    unique case (op_r)
      OP_ALLOC: begin
        if (is_tgt) begin
          upd.st     = SS_RUNNING;
          upd.prio   = prio_r;
          upd.pid    = newpid_r;
          upd.parent = (pv_r && 32'(par_r) < PROC_SLOTS) ? PARENT_W'(par_r) : NO_PARENT;
        end
      end
      OP_SLEEP: begin
        if (is_tgt) begin
          upd.st  = SS_SLEEPING;
          upd.tag = chan_r;
        end
      end
      OP_WAKEUP: begin
        if (rec.st == SS_SLEEPING && rec.tag == chan_r) begin
          upd.st = SS_RUNNING;
        end
      end
      OP_PICK: begin
        if (rec.st == SS_RUNNING || rec.st == SS_SLEEPING) begin
          upd.count = {1'b0, rec.count[COUNT_W-1:1]} + {1'b0, rec.prio};
        end
      end
      OP_TICK: begin
        if (is_tgt && rec.count != '0) begin
          upd.count = rec.count - 1'b1;
        end
      end
      OP_EXIT: begin
        if (rec.parent == PARENT_W'(slot_r)) begin
          upd.parent = adopt;
        end
        if (is_tgt) begin
          upd.st = SS_ZOMBIE;
        end
      end
      OP_REAP: begin
        if (is_tgt) begin
          upd.st     = SS_UNUSED;
          upd.pid    = '0;
          upd.parent = NO_PARENT;
        end
      end
      default: upd = rec;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    init_nxt     = cfg_wen ? cfg_wdata : init_r;
    pidc_nxt     = pidc_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    op_nxt       = op_r;
    slot_nxt     = slot_r;
    chan_nxt     = chan_r;
    prio_nxt     = prio_r;
    par_nxt      = par_r;
    pv_nxt       = pv_r;
    free_fnd_nxt = free_fnd_r;
    free_idx_nxt = free_idx_r;
    kid_fnd_nxt  = kid_fnd_r;
    kid_idx_nxt  = kid_idx_r;
    kid_pid_nxt  = kid_pid_r;
    best_fnd_nxt = best_fnd_r;
    best_idx_nxt = best_idx_r;
    best_cnt_nxt = best_cnt_r;
    self_st_nxt  = self_st_r;
    tgt_nxt      = tgt_r;
    newpid_nxt   = newpid_r;
    stat_nxt     = stat_r;
    chos_nxt     = chos_r;
    rpid_nxt     = rpid_r;
    ram_we       = 1'b0;
    ram_waddr    = rd_idx_r;
    ram_wdata    = upd;
    ram_raddr    = cnt_r[AW-1:0];
    apply        = 1'b0;

    // Issue reads one slot a cycle during both passes.
    if ((state_r == S_SCAN || state_r == S_APPLY) && cnt_r < CNT_END) begin
      cnt_nxt    = cnt_r + 1'b1;
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = cnt_r[AW-1:0];
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = rst_rec;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt       = op_t'(in_tdata[2:0]);
          slot_nxt     = in_tdata[8:3];
          chan_nxt     = in_tdata[24:9];
          prio_nxt     = in_tdata[30:25];
          par_nxt      = in_tdata[36:31];
          pv_nxt       = in_tdata[37];
          free_fnd_nxt = 1'b0;
          kid_fnd_nxt  = 1'b0;
          kid_pid_nxt  = '0;
          best_fnd_nxt = 1'b0;
          best_cnt_nxt = '0;
          self_st_nxt  = SS_UNUSED;
          stat_nxt     = RS_DONE;
          chos_nxt     = '0;
          rpid_nxt     = '0;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          if (rec.st == SS_UNUSED && !free_fnd_r) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (rec.st == SS_ZOMBIE && rec.parent == PARENT_W'(slot_r) && !kid_fnd_r) begin
            kid_fnd_nxt = 1'b1;
            kid_idx_nxt = rd_idx_r;
            kid_pid_nxt = rec.pid;
          end
          if (rec.st == SS_RUNNING && rec.count > best_cnt_r) begin
            best_fnd_nxt = 1'b1;
            best_idx_nxt = rd_idx_r;
            best_cnt_nxt = rec.count;
          end
          if (is_self) begin
            self_st_nxt = rec.st;
          end
        end
        if (last) begin
          tgt_nxt = AW'(slot_r);
          unique case (op_r)
            OP_ALLOC: begin
              if (free_fnd_nxt) begin
                apply      = 1'b1;
                tgt_nxt    = free_idx_nxt;
                newpid_nxt = pidc_r + 1'b1;
                pidc_nxt   = pidc_r + 1'b1;
                chos_nxt   = SLOT_W'(free_idx_nxt);
                rpid_nxt   = pidc_r + 1'b1;
              end else begin
                stat_nxt = RS_NONE;
              end
            end
            OP_SLEEP, OP_TICK: begin
              if (slot_ok && self_st_nxt == SS_RUNNING) begin
                apply = 1'b1;
              end else begin
                stat_nxt = RS_REFUSED;
              end
            end
            OP_WAKEUP: apply = 1'b1;
            OP_PICK: begin
              if (best_fnd_nxt) begin
                chos_nxt = SLOT_W'(best_idx_nxt);
              end else begin
                apply = 1'b1;
              end
            end
            OP_EXIT: begin
              if (slot_ok && slot_r != init_r &&
                  (self_st_nxt == SS_RUNNING || self_st_nxt == SS_SLEEPING)) begin
                apply = 1'b1;
              end else begin
                stat_nxt = RS_REFUSED;
              end
            end
            OP_REAP: begin
              if (!slot_ok) begin
                stat_nxt = RS_REFUSED;
              end else if (kid_fnd_nxt) begin
                apply    = 1'b1;
                tgt_nxt  = kid_idx_nxt;
                rpid_nxt = kid_pid_nxt;
              end else begin
                stat_nxt = RS_NONE;
              end
            end
            default: stat_nxt = RS_REFUSED;
          endcase
          if (apply) begin
            cnt_nxt      = '0;
            best_fnd_nxt = 1'b0;
            best_cnt_nxt = '0;
            state_nxt    = S_APPLY;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_APPLY: begin
        if (rd_vld_r) begin
          ram_we = 1'b1;
          // Search the recounted values as they are written back.
          if (upd.st == SS_RUNNING && upd.count > best_cnt_r) begin
            best_fnd_nxt = 1'b1;
            best_idx_nxt = rd_idx_r;
            best_cnt_nxt = upd.count;
          end
        end
        if (last) begin
          if (op_r == OP_PICK) begin
            if (best_fnd_nxt) begin
              chos_nxt = SLOT_W'(best_idx_nxt);
            end else begin
              stat_nxt = RS_NONE;
            end
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {rpid_r, chos_r, stat_r};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      init_r    <= '0;
      pidc_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      init_r    <= init_nxt;
      pidc_r    <= pidc_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    chan_r     <= chan_nxt;
    prio_r     <= prio_nxt;
    par_r      <= par_nxt;
    pv_r       <= pv_nxt;
    free_fnd_r <= free_fnd_nxt;
    free_idx_r <= free_idx_nxt;
    kid_fnd_r  <= kid_fnd_nxt;
    kid_idx_r  <= kid_idx_nxt;
    kid_pid_r  <= kid_pid_nxt;
    best_fnd_r <= best_fnd_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    self_st_r  <= self_st_nxt;
    tgt_r      <= tgt_nxt;
    newpid_r   <= newpid_nxt;
    stat_r     <= stat_nxt;
    chos_r     <= chos_nxt;
    rpid_r     <= rpid_nxt;
  end

  a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_APPLY || state_r == S_CLEAR))
    else $error("table written outside clear or apply pass");

  a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN || state_r == S_APPLY))
    else $error("read data pending outside a pass");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && (!out_vld_r || out_tready)) |=> (out_tvalid && state_r == S_IDLE))
    else $error("finished item not presented");

endmodule
